// ===== design/ptd_pkg.sv =====
// ptd_pkg: command and status types shared by the trial-division
// controller and datapath. No dependencies.
package ptd_pkg;

  typedef struct packed {
    logic load;       // capture candidate, divisor = 3
    logic start_div;  // clear remainder, load dividend
    logic step;       // one restoring-division bit
    logic next_d;     // divisor += 2
  } ptd_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_lt4;
    logic n_even;
    logic div_last;
    logic d_gt_q;
    logic rem_zero;
  } ptd_status_t;

endpackage

// ===== design/ptd_datapath.sv =====
// ptd_datapath: candidate and divisor registers plus a bit-serial
// restoring divider giving quotient and remainder. Uses ptd_pkg.
module ptd_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] in_candidate,
  input  ptd_pkg::ptd_cmd_t      cmd,
  output ptd_pkg::ptd_status_t   status
);
  import ptd_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = (W > 2) ? $clog2(W) : 1;

  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [W:0] rem_shift;
  logic [W:0] rem_diff;
  logic       fits;

  assign rem_shift = {rem_r, quo_r[W-1]};
  assign rem_diff  = rem_shift - {1'b0, d_r};
  assign fits      = rem_shift >= {1'b0, d_r};

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      n_nxt = in_candidate;
      d_nxt = W'(3);
    end
    if (cmd.start_div) begin
      rem_nxt = '0;
      quo_nxt = n_r;
      cnt_nxt = CW'(W - 1);
    end
    if (cmd.step) begin
      if (fits) begin
        rem_nxt = rem_diff[W-1:0];
      end else begin
        rem_nxt = rem_shift[W-1:0];
      end
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.next_d) begin
      d_nxt = d_r + W'(2);
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign status.n_lt2    = n_r < W'(2);
  assign status.n_lt4    = n_r < W'(3) || n_r == W'(3);
  assign status.n_even   = ~n_r[0];
  assign status.div_last = cnt_r == '0;
  assign status.d_gt_q   = d_r > quo_r;
  assign status.rem_zero = rem_r == '0;

endmodule

// ===== design/ptd_controller.sv =====
// ptd_controller: sequencer for the trial-division test and the result
// output register. Uses ptd_pkg.
module ptd_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_prime,
  input  ptd_pkg::ptd_status_t status,
  output ptd_pkg::ptd_cmd_t    cmd
);
  import ptd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLASS  = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_prime_r, out_is_prime_nxt;

  always_comb begin
    state_nxt        = state_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r & ~out_ready;
    out_is_prime_nxt = out_is_prime_r;
    cmd              = '0;
    in_ready         = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (status.n_lt2) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else if (status.n_lt4) begin
          res_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (status.n_even) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start_div = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.d_gt_q) begin
          res_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (status.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cmd.next_d = 1'b1;
          state_nxt  = S_START;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r          <= res_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

// ===== design/prime_trial_division.sv =====
// prime_trial_division: top level of the trial-division primality test.
// Depends on ptd_pkg, ptd_controller and ptd_datapath.
//
//   channel | ports                              | word
//   input   | in_valid, in_ready, in_candidate   | value to test
//   output  | out_valid, out_ready, out_is_prime | 1 = prime
//
// One word at a time. Zero, one, two, three and even values are decided
// directly; odd values are divided by odd divisors from 3 while d <= n/d,
// each in the one-bit-per-cycle serial divider.
// Synchronous active-low reset clears the sequencer and the output valid.
// The output register lets the next word be taken while a result waits.
module prime_trial_division #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_candidate,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_is_prime
);
  import ptd_pkg::*;

  ptd_cmd_t    cmd;
  ptd_status_t status;

  ptd_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime),
    .status       (status),
    .cmd          (cmd)
  );

  ptd_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .in_candidate (in_candidate),
    .cmd          (cmd),
    .status       (status)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start_div, cmd.step, cmd.next_d}))
    else $error("more than one datapath command");

  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.start_div || cmd.step || cmd.next_d))
    else $error("datapath busy while taking a word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken during a test");

endmodule
